>>> design/reversible_deque_top_assert.svh
// Assertion macros used by the file that checks the queue.
`ifndef REVERSIBLE_DEQUE_TOP_ASSERT_SVH
`define REVERSIBLE_DEQUE_TOP_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define RDQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define RDQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rdq_pkg.sv
package rdq_pkg;

  typedef enum logic [2:0] {
    CMD_TAKE_BACK  = 3'd0,
    CMD_TAKE_FRONT = 3'd1,
    CMD_REVERSE    = 3'd2,
    CMD_PUSH_BACK  = 3'd3,
    CMD_PUSH_FRONT = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TAKE_HEAD,
    OP_TAKE_TAIL,
    OP_PUSH_HEAD,
    OP_PUSH_TAIL,
    OP_FLIP
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic    load;
    op_t     op;
    status_t rstat;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic reversed;
  } dp_stat_t;

endpackage

>>> design/rdq_ram.sv
module rdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/rdq_ctrl.sv
module rdq_ctrl import rdq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] cmd,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  ctl,
  output logic       busy,
  output logic       strobe
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.load   = 1'b0;
    ctl.op     = OP_NONE;
    ctl.rstat  = ST_DONE;
    busy       = 1'b0;
    strobe     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_RESP;
          unique case (cmd_t'(cmd))
            CMD_TAKE_BACK: begin
              if (stat.empty) begin
                ctl.rstat = ST_EMPTY;
              end else begin
                ctl.op = stat.reversed ? OP_TAKE_HEAD : OP_TAKE_TAIL;
              end
            end
            CMD_TAKE_FRONT: begin
              if (stat.empty) begin
                ctl.rstat = ST_EMPTY;
              end else begin
                ctl.op = stat.reversed ? OP_TAKE_TAIL : OP_TAKE_HEAD;
              end
            end
            CMD_REVERSE: begin
              ctl.op = OP_FLIP;
            end
            CMD_PUSH_BACK: begin
              if (stat.full) begin
                ctl.rstat = ST_FULL;
              end else begin
                ctl.op = stat.reversed ? OP_PUSH_HEAD : OP_PUSH_TAIL;
              end
            end
            CMD_PUSH_FRONT: begin
              if (stat.full) begin
                ctl.rstat = ST_FULL;
              end else begin
                ctl.op = stat.reversed ? OP_PUSH_TAIL : OP_PUSH_HEAD;
              end
            end
            default: begin
              ctl.op = OP_NONE;
            end
          endcase
        end
      end
      S_RESP: begin
        busy       = 1'b1;
        strobe     = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/rdq_dp.sv
module rdq_dp import rdq_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int PTR_W = 10,
  parameter int CNT_W = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          ctl,
  input  logic [31:0]        value,
  output dp_stat_t           stat,
  output status_t            status,
  output logic [31:0]        data,
  output logic [CNT_W-1:0]   count
);

  logic [PTR_W-1:0] head_ptr;
  logic [PTR_W-1:0] tail_ptr;
  logic [CNT_W-1:0] occupancy;
  logic             reversed;
  status_t          res_status;
  logic             res_take;

  logic [PTR_W-1:0] head_dec;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] tail_inc;
  logic [PTR_W-1:0] tail_dec;
  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  logic [PTR_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  assign head_dec = (head_ptr == '0) ? PTR_W'(DEPTH - 1) : head_ptr - 1'b1;
  assign head_inc = (head_ptr == PTR_W'(DEPTH - 1)) ? '0 : head_ptr + 1'b1;
  assign tail_dec = (tail_ptr == '0) ? PTR_W'(DEPTH - 1) : tail_ptr - 1'b1;
  assign tail_inc = (tail_ptr == PTR_W'(DEPTH - 1)) ? '0 : tail_ptr + 1'b1;

  assign stat.empty    = (occupancy == '0);
  assign stat.full     = (occupancy == CNT_W'(DEPTH));
  assign stat.reversed = reversed;

  assign ram_we    = ctl.load && (ctl.op == OP_PUSH_HEAD || ctl.op == OP_PUSH_TAIL);
  assign ram_waddr = (ctl.op == OP_PUSH_HEAD) ? head_dec : tail_inc;
  assign ram_raddr = (ctl.op == OP_TAKE_HEAD) ? head_ptr : tail_ptr;

  rdq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr  <= '0;
      tail_ptr  <= PTR_W'(DEPTH - 1);
      occupancy <= '0;
      reversed  <= 1'b0;
    end else if (ctl.load) begin
      unique case (ctl.op)
        OP_TAKE_HEAD: begin
          head_ptr  <= head_inc;
          occupancy <= occupancy - 1'b1;
        end
        OP_TAKE_TAIL: begin
          tail_ptr  <= tail_dec;
          occupancy <= occupancy - 1'b1;
        end
        OP_PUSH_HEAD: begin
          head_ptr  <= head_dec;
          occupancy <= occupancy + 1'b1;
        end
        OP_PUSH_TAIL: begin
          tail_ptr  <= tail_inc;
          occupancy <= occupancy + 1'b1;
        end
        OP_FLIP: begin
          reversed <= !reversed;
        end
        default: begin
          occupancy <= occupancy;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res_status <= ctl.rstat;
      res_take   <= (ctl.op == OP_TAKE_HEAD || ctl.op == OP_TAKE_TAIL);
    end
  end

  assign status = res_status;
  assign data   = res_take ? ram_rdata : '0;
  assign count  = occupancy;

endmodule

>>> design/reversible_deque_top.sv
// Double-ended queue of signed 32-bit words with an in-place reverse. An item
// is accepted when start is high and busy is low; its result appears on status,
// data and count in the next cycle, for that one cycle only, marked by strobe,
// and must be captured then because the receiver cannot stall the block. Busy
// is high in that result cycle, so no new item is accepted until it ends; the
// data word comes from the registered read port of the word memory. Memory
// contents are undefined until pushed, and no clearing pass runs after reset.
module reversible_deque_top import rdq_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       cmd,
  input  logic signed [31:0]               value,
  output logic                             strobe,
  output logic [1:0]                       status,
  output logic signed [31:0]               data,
  output logic [$clog2(DEPTH + 1)-1:0]     count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ctrl_cmd_t ctl;
  dp_stat_t  stat;
  status_t   res_status;
  logic [31:0] res_data;

  rdq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .strobe(strobe)
  );

  rdq_dp #(
    .DEPTH(DEPTH),
    .PTR_W(PTR_W),
    .CNT_W(CNT_W)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .value (value),
    .stat  (stat),
    .status(res_status),
    .data  (res_data),
    .count (count)
  );

  assign status = res_status;
  assign data   = res_data;

endmodule

>>> design/rdq_checker.sv
`include "reversible_deque_top_assert.svh"

module rdq_checker import rdq_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         strobe,
  input logic [1:0]                   status,
  input logic [31:0]                  data,
  input logic [$clog2(DEPTH + 1)-1:0] count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  `RDQ_ASSERT_NEXT(a_result_follows, clk, rst, start && !busy, strobe, "no result after item")
  `RDQ_ASSERT_NOW(a_empty_count, clk, rst, strobe && status == ST_EMPTY, count == '0,
                  "empty with entries")
  `RDQ_ASSERT_NOW(a_full_count, clk, rst, strobe && status == ST_FULL, count == CNT_W'(DEPTH),
                  "full below depth")
  `RDQ_ASSERT_NOW(a_fail_data, clk, rst, strobe && status != ST_DONE, data == '0,
                  "data on failed item")

endmodule

bind reversible_deque_top rdq_checker #(.DEPTH(DEPTH)) u_rdq_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .strobe(strobe),
  .status(status),
  .data  (data),
  .count (count)
);
